FILE: hw/rtl/ctc_pkg.sv
package ctc_pkg;

    // Button codes carried with a press
    localparam logic [1:0] BTN_OK    = 2'd0;
    localparam logic [1:0] BTN_UP    = 2'd1;
    localparam logic [1:0] BTN_DOWN  = 2'd2;

    // Event kinds
    localparam logic OP_PRESS = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Sound requests
    localparam logic [1:0] SND_NONE  = 2'd0;
    localparam logic [1:0] SND_BEEP  = 2'd1;
    localparam logic [1:0] SND_ALARM = 2'd2;

    // Mode codes reported on the result
    localparam logic [1:0] MODE_CODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_CODE_SET  = 2'd1;
    localparam logic [1:0] MODE_CODE_HEAT = 2'd2;

    // Digit selection
    localparam logic DIGIT_ONES = 1'b0;
    localparam logic DIGIT_TENS = 1'b1;

    localparam logic [3:0] DIGIT_MAX  = 4'd9;
    localparam logic [3:0] HOLD_RESET = 4'd5;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_SET  = 3'b010,
        MODE_HEAT = 3'b100
    } mode_t;

    typedef struct packed {
        logic       operation;
        logic [1:0] button;
    } event_t;

    typedef struct packed {
        logic       heater_drive;
        logic [1:0] sound;
        logic [3:0] shown_ones;
        logic [3:0] shown_tens;
        logic       blink_ones;
        logic       blink_tens;
        logic [1:0] mode_now;
    } status_t;

endpackage

FILE: hw/rtl/ctc_stream_if.sv
interface ctc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/cooking_timer_controller_core.sv
// Latency: a result appears in the cycle after its request is accepted.
// Throughput: one request per cycle while status.ready is high; the state
// update is a single pass of logic between the state and result registers.
// A new request is accepted in the same cycle that a waiting result is taken.
// Reset (rst_n low, asynchronous): idle mode, target and countdown 00,
// alarm hold 5 ticks, no result pending.
module cooking_timer_controller_core
    import ctc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    ctc_stream_if.sink          events,
    ctc_stream_if.source        status,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_wdata
);

    mode_t       mode_reg, mode_next;
    logic        edit_reg, edit_next;
    logic [3:0]  tgt_ones_reg, tgt_ones_next;
    logic [3:0]  tgt_tens_reg, tgt_tens_next;
    logic [3:0]  rem_ones_reg, rem_ones_next;
    logic [3:0]  rem_tens_reg, rem_tens_next;
    logic        timed_out_reg, timed_out_next;
    logic [3:0]  hold_reg, hold_next;
    logic [3:0]  alarm_hold_reg;
    logic        out_valid_reg;
    status_t     out_reg, out_next;
    logic [1:0]  snd_next;
    logic        accept;
    event_t      ev;

    assign ev            = events.payload;
    assign events.ready  = !out_valid_reg || status.ready;
    assign accept        = events.valid && events.ready;
    assign status.valid  = out_valid_reg;
    assign status.payload = out_reg;

    // Compute the state update and the result for one request
    always_comb
    begin
        logic [3:0] sel;
        logic [3:0] ro;
        logic [3:0] rt;
        logic [4:0] hold_inc;

        mode_next      = mode_reg;
        edit_next      = edit_reg;
        tgt_ones_next  = tgt_ones_reg;
        tgt_tens_next  = tgt_tens_reg;
        rem_ones_next  = rem_ones_reg;
        rem_tens_next  = rem_tens_reg;
        timed_out_next = timed_out_reg;
        hold_next      = hold_reg;
        snd_next       = SND_NONE;

        sel      = (edit_reg == DIGIT_TENS) ? tgt_tens_reg : tgt_ones_reg;
        ro       = rem_ones_reg;
        rt       = rem_tens_reg;
        hold_inc = {1'b0, hold_reg} + 5'd1;

        if (ev.operation == OP_TICK)
        begin
            // Count down, then hold the blinking 00
            if (mode_reg == MODE_HEAT)
            begin
                if (!timed_out_reg)
                begin
                    if (ro != 4'd0)
                    begin
                        ro = ro - 4'd1;
                    end
                    else if (rt != 4'd0)
                    begin
                        rt = rt - 4'd1;
                        ro = DIGIT_MAX;
                    end
                    rem_ones_next = ro;
                    rem_tens_next = rt;
                    if (ro == 4'd0 && rt == 4'd0)
                    begin
                        timed_out_next = 1'b1;
                        hold_next      = 4'd0;
                        snd_next       = SND_ALARM;
                    end
                end
                else if (hold_inc >= {1'b0, alarm_hold_reg})
                begin
                    mode_next      = MODE_IDLE;
                    timed_out_next = 1'b0;
                    hold_next      = 4'd0;
                end
                else
                begin
                    hold_next = hold_inc[3:0];
                end
            end
        end
        else
        begin
            case (mode_reg)
                MODE_IDLE:
                begin
                    if (ev.button == BTN_OK)
                    begin
                        mode_next = MODE_SET;
                        edit_next = DIGIT_ONES;
                        snd_next  = SND_BEEP;
                    end
                end
                MODE_SET:
                begin
                    // Edit the selected digit, clamped to 0..9
                    if (ev.button == BTN_UP || ev.button == BTN_DOWN)
                    begin
                        snd_next = SND_BEEP;
                        if (ev.button == BTN_UP && sel < DIGIT_MAX)
                        begin
                            sel = sel + 4'd1;
                        end
                        else if (ev.button == BTN_DOWN && sel != 4'd0)
                        begin
                            sel = sel - 4'd1;
                        end
                        if (edit_reg == DIGIT_TENS)
                        begin
                            tgt_tens_next = sel;
                        end
                        else
                        begin
                            tgt_ones_next = sel;
                        end
                    end
                    else if (ev.button == BTN_OK)
                    begin
                        snd_next = SND_BEEP;
                        if (edit_reg == DIGIT_ONES)
                        begin
                            edit_next = DIGIT_TENS;
                        end
                        else
                        begin
                            edit_next      = DIGIT_ONES;
                            mode_next      = MODE_HEAT;
                            rem_ones_next  = tgt_ones_reg;
                            rem_tens_next  = tgt_tens_reg;
                            timed_out_next = 1'b0;
                            hold_next      = 4'd0;
                        end
                    end
                end
                MODE_HEAT:
                begin
                    // Cancel
                    if (ev.button == BTN_OK)
                    begin
                        mode_next      = MODE_IDLE;
                        timed_out_next = 1'b0;
                        hold_next      = 4'd0;
                        snd_next       = SND_BEEP;
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end
    end

    // Build the result from the updated state
    always_comb
    begin
        out_next            = '0;
        out_next.sound      = snd_next;
        out_next.shown_ones = tgt_ones_next;
        out_next.shown_tens = tgt_tens_next;
        case (mode_next)
            MODE_HEAT:
            begin
                out_next.mode_now     = MODE_CODE_HEAT;
                out_next.shown_ones   = rem_ones_next;
                out_next.shown_tens   = rem_tens_next;
                out_next.heater_drive = !timed_out_next;
                out_next.blink_ones   = timed_out_next;
                out_next.blink_tens   = timed_out_next;
            end
            MODE_SET:
            begin
                out_next.mode_now   = MODE_CODE_SET;
                out_next.blink_ones = (edit_next == DIGIT_ONES);
                out_next.blink_tens = (edit_next == DIGIT_TENS);
            end
            default:
            begin
                out_next.mode_now = MODE_CODE_IDLE;
            end
        endcase
    end

    // Advance state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            edit_reg      <= DIGIT_ONES;
            tgt_ones_reg  <= 4'd0;
            tgt_tens_reg  <= 4'd0;
            rem_ones_reg  <= 4'd0;
            rem_tens_reg  <= 4'd0;
            timed_out_reg <= 1'b0;
            hold_reg      <= 4'd0;
        end
        else if (accept)
        begin
            mode_reg      <= mode_next;
            edit_reg      <= edit_next;
            tgt_ones_reg  <= tgt_ones_next;
            tgt_tens_reg  <= tgt_tens_next;
            rem_ones_reg  <= rem_ones_next;
            rem_tens_reg  <= rem_tens_next;
            timed_out_reg <= timed_out_next;
            hold_reg      <= hold_next;
        end
    end

    // Hold the alarm length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_hold_reg <= HOLD_RESET;
        end
        else if (cfg_we)
        begin
            alarm_hold_reg <= cfg_wdata;
        end
    end

    // Result valid: set on accept, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

    // Countdown digits stay decimal
    assert property (@(posedge clk) disable iff (!rst_n)
        rem_ones_reg <= DIGIT_MAX && rem_tens_reg <= DIGIT_MAX)
        else $error("countdown digit out of range");

    // An alarm result leaves the block timed out in heat mode
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && snd_next == SND_ALARM |=> timed_out_reg && mode_reg == MODE_HEAT)
        else $error("alarm without timeout state");

    // A heating result never blinks and always reports heat mode
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.heater_drive |->
            out_reg.mode_now == MODE_CODE_HEAT && !out_reg.blink_ones && !out_reg.blink_tens)
        else $error("heater result inconsistent");

    // Timed-out state only exists while heating
    assert property (@(posedge clk) disable iff (!rst_n)
        timed_out_reg |-> mode_reg == MODE_HEAT && rem_ones_reg == 4'd0 && rem_tens_reg == 4'd0)
        else $error("timeout outside heat mode");

endmodule

FILE: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ctc_pkg::*;

    localparam logic [1:0] BTN_OTHER   = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         RANDOM_ITEMS = 600;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we;
    logic [3:0] cfg_wdata;

    ctc_stream_if #(.payload_t(event_t))  event_bus ();
    ctc_stream_if #(.payload_t(status_t)) status_bus ();

    cooking_timer_controller_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .events    (event_bus),
        .status    (status_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Timer state as the block should hold it
    mode_t      oven_mode;
    logic       sel_tens;
    logic [3:0] tgt_ones;
    logic [3:0] tgt_tens;
    logic [3:0] left_ones;
    logic [3:0] left_tens;
    logic       timed_out;
    logic [3:0] hold_cnt;
    logic [3:0] hold_len;

    status_t    status_due[$];
    int         errors = 0;
    int         events_sent = 0;
    int         cycle_count = 0;
    logic       no_idle = 1'b0;
    logic [3:0] hold_plan [4] = '{4'd15, 4'd1, 4'd0, 4'd5};

    // Clock: 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Guard against a hung handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Stall the status side at random
    always @(posedge clk)
    begin
        status_bus.ready <= no_idle || ($urandom_range(0, 99) >= 23);
    end

    function automatic void reset_timer_model();
        oven_mode = MODE_IDLE;
        sel_tens  = DIGIT_ONES;
        tgt_ones  = '0;
        tgt_tens  = '0;
        left_ones = '0;
        left_tens = '0;
        timed_out = 1'b0;
        hold_cnt  = '0;
        hold_len  = HOLD_RESET;
    endfunction

    function automatic void drop_to_idle();
        oven_mode = MODE_IDLE;
        timed_out = 1'b0;
        hold_cnt  = '0;
    endfunction

    // Advance the timer by one request and build the status it reports
    function automatic status_t step_timer(input logic op, input logic [1:0] btn);
        status_t    r;
        logic [1:0] snd;
        logic [3:0] digit;
        logic [4:0] next_hold;
        snd = SND_NONE;
        if (op == OP_TICK)
        begin
            if (oven_mode == MODE_HEAT && !timed_out)
            begin
                // count down, borrowing from tens
                if (left_ones != 4'd0)
                    left_ones = left_ones - 4'd1;
                else if (left_tens != 4'd0)
                begin
                    left_tens = left_tens - 4'd1;
                    left_ones = DIGIT_MAX;
                end
                if (left_ones == 4'd0 && left_tens == 4'd0)
                begin
                    timed_out = 1'b1;
                    hold_cnt  = '0;
                    snd       = SND_ALARM;
                end
            end
            else if (oven_mode == MODE_HEAT)
            begin
                next_hold = {1'b0, hold_cnt} + 5'd1;
                if (next_hold >= {1'b0, hold_len})
                    drop_to_idle();
                else
                    hold_cnt = next_hold[3:0];
            end
        end
        else
        begin
            case (oven_mode)
                MODE_IDLE:
                begin
                    if (btn == BTN_OK)
                    begin
                        oven_mode = MODE_SET;
                        sel_tens  = DIGIT_ONES;
                        snd       = SND_BEEP;
                    end
                end
                MODE_SET:
                begin
                    if (btn == BTN_UP || btn == BTN_DOWN)
                    begin
                        digit = (sel_tens == DIGIT_TENS) ? tgt_tens : tgt_ones;
                        if (btn == BTN_UP && digit < DIGIT_MAX)
                            digit = digit + 4'd1;
                        if (btn == BTN_DOWN && digit != 4'd0)
                            digit = digit - 4'd1;
                        if (sel_tens == DIGIT_TENS)
                            tgt_tens = digit;
                        else
                            tgt_ones = digit;
                        snd = SND_BEEP;
                    end
                    else if (btn == BTN_OK)
                    begin
                        if (sel_tens == DIGIT_ONES)
                            sel_tens = DIGIT_TENS;
                        else
                        begin
                            sel_tens  = DIGIT_ONES;
                            oven_mode = MODE_HEAT;
                            left_ones = tgt_ones;
                            left_tens = tgt_tens;
                            timed_out = 1'b0;
                            hold_cnt  = '0;
                        end
                        snd = SND_BEEP;
                    end
                end
                default:
                begin
                    if (btn == BTN_OK)
                    begin
                        drop_to_idle();
                        snd = SND_BEEP;
                    end
                end
            endcase
        end

        r = '0;
        r.sound = snd;
        if (oven_mode == MODE_HEAT)
        begin
            r.shown_ones = left_ones;
            r.shown_tens = left_tens;
            r.mode_now   = MODE_CODE_HEAT;
            if (timed_out)
            begin
                r.blink_ones = 1'b1;
                r.blink_tens = 1'b1;
            end
            else
                r.heater_drive = 1'b1;
        end
        else
        begin
            r.shown_ones = tgt_ones;
            r.shown_tens = tgt_tens;
            if (oven_mode == MODE_SET)
            begin
                r.mode_now   = MODE_CODE_SET;
                r.blink_tens = (sel_tens == DIGIT_TENS);
                r.blink_ones = (sel_tens == DIGIT_ONES);
            end
            else
                r.mode_now = MODE_CODE_IDLE;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Compare each status taken downstream with the oldest prediction
    initial
    begin : status_checker
        status_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && status_bus.valid && status_bus.ready)
            begin
                if (status_due.size() == 0)
                begin
                    $error("status: none expected, got %p", status_bus.payload);
                    errors++;
                end
                else
                begin
                    want = status_due.pop_front();
                    check_field("heater_drive", want.heater_drive,
                                status_bus.payload.heater_drive);
                    check_field("sound", want.sound, status_bus.payload.sound);
                    check_field("shown_ones", want.shown_ones, status_bus.payload.shown_ones);
                    check_field("shown_tens", want.shown_tens, status_bus.payload.shown_tens);
                    check_field("blink_ones", want.blink_ones, status_bus.payload.blink_ones);
                    check_field("blink_tens", want.blink_tens, status_bus.payload.blink_tens);
                    check_field("mode_now", want.mode_now, status_bus.payload.mode_now);
                end
            end
        end
    end

    // Send one request; valid stays high afterwards for a back-to-back request
    task automatic send_event(input logic op, input logic [1:0] btn);
        event_t item;
        item.operation = op;
        item.button    = btn;
        while (!no_idle && $urandom_range(0, 99) < 23)
        begin
            event_bus.valid <= 1'b0;
            @(posedge clk);
        end
        event_bus.valid   <= 1'b1;
        event_bus.payload <= item;
        do
            @(negedge clk);
        while (!event_bus.ready);
        @(posedge clk);
        status_due.push_back(step_timer(op, btn));
        events_sent++;
    endtask

    task automatic press(input logic [1:0] btn);
        send_event(OP_PRESS, btn);
    endtask

    task automatic tick();
        send_event(OP_TICK, BTN_OK);
    endtask

    // Drop valid and hold until every status has come back
    task automatic drain();
        event_bus.valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_hold(input logic [3:0] ticks);
        cfg_we    <= 1'b1;
        cfg_wdata <= ticks;
        @(posedge clk);
        cfg_we   <= 1'b0;
        hold_len = ticks;
    endtask

    task automatic test_idle_ignores();
        tick();
        press(BTN_UP);
        press(BTN_DOWN);
        press(BTN_OTHER);
    endtask

    // Edit both digits to 11, count down through a borrow, then cancel
    task automatic test_set_and_borrow();
        press(BTN_OK);
        press(BTN_DOWN);
        press(BTN_UP);
        press(BTN_OTHER);
        tick();
        press(BTN_OK);
        press(BTN_UP);
        press(BTN_OK);
        press(BTN_UP);
        tick();
        tick();
        press(BTN_OK);
    endtask

    // Start from 00, time out on the first tick, cancel during the hold
    task automatic test_zero_target_and_hold();
        press(BTN_OK);
        press(BTN_DOWN);
        press(BTN_OK);
        press(BTN_DOWN);
        press(BTN_OK);
        tick();
        tick();
        press(BTN_OK);
    endtask

    // Press up or down on the selected digit, with some ignored noise
    task automatic edit_presses(input int count, input int up_pct);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 8)
                send_event($urandom_range(0, 1) ? OP_TICK : OP_PRESS, BTN_OTHER);
            else
                press(($urandom_range(0, 99) < up_pct) ? BTN_UP : BTN_DOWN);
        end
    endtask

    // One full cooking session: set a target, heat, time out or get cancelled
    task automatic random_cook_cycle();
        int up_pct;
        int ticks_needed;
        int ticks_run;
        up_pct = $urandom_range(0, 1) ? 75 : 35;
        while (oven_mode != MODE_SET)
            press(BTN_OK);
        if (sel_tens == DIGIT_ONES)
        begin
            edit_presses($urandom_range(0, 12), up_pct);
            press(BTN_OK);
        end
        if ($urandom_range(0, 7) == 0)
            edit_presses($urandom_range(0, 12), up_pct);
        else
            edit_presses($urandom_range(0, 3), 40);
        press(BTN_OK);

        ticks_needed = int'(left_tens) * 10 + int'(left_ones) + int'(hold_len) + 1;
        if ($urandom_range(0, 3) != 0)
            ticks_run = ticks_needed + $urandom_range(0, 2);
        else
            ticks_run = $urandom_range(0, ticks_needed);
        for (int i = 0; i < ticks_run; i++)
        begin
            if ($urandom_range(0, 99) < 10)
                press(2'($urandom_range(0, 3)));
            else
                tick();
        end
    endtask

    task automatic test_random_mix();
        int start_count;
        int session;
        start_count = events_sent;
        session = 0;
        while (events_sent - start_count < RANDOM_ITEMS)
        begin
            // change the hold length between groups of sessions
            if (session % 4 == 0)
            begin
                drain();
                if (session / 4 < 4)
                    write_hold(hold_plan[session / 4]);
                else
                    write_hold(4'($urandom_range(1, 15)));
            end
            no_idle = (session >= 8 && session < 12);
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 8))
                    send_event(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            end
            random_cook_cycle();
            session++;
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        event_bus.valid   = 1'b0;
        event_bus.payload = '0;
        status_bus.ready  = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        reset_timer_model();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_ignores();
        test_set_and_borrow();
        test_zero_target_and_hold();
        test_random_mix();
        drain();

        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
